// File: rtl/oidh_pkg.sv
// ----------------------------------------------------------------------------
// oidh_pkg
// Shared types and constants for the Ogg Opus identification header parser:
// item structs, controller commands and status, state encoding, magic.
// ----------------------------------------------------------------------------
package oidh_pkg;

    // Largest channel count whose map entries are stored
    localparam int MAX_CHANNELS = 8;
    localparam int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Header layout
    localparam int POS_W    = 16;
    localparam int HE_W     = 9;
    localparam int MIN_LEN  = 19;
    localparam int MAP_BASE = 21;

    localparam logic [POS_W-1:0] POS_VERSION  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_CHANNELS = POS_W'(9);
    localparam logic [POS_W-1:0] POS_PRE_LO   = POS_W'(10);
    localparam logic [POS_W-1:0] POS_PRE_HI   = POS_W'(11);
    localparam logic [POS_W-1:0] POS_RATE_0   = POS_W'(12);
    localparam logic [POS_W-1:0] POS_RATE_3   = POS_W'(15);
    localparam logic [POS_W-1:0] POS_GAIN_LO  = POS_W'(16);
    localparam logic [POS_W-1:0] POS_GAIN_HI  = POS_W'(17);
    localparam logic [POS_W-1:0] POS_FAMILY   = POS_W'(18);
    localparam logic [POS_W-1:0] POS_STREAMS  = POS_W'(19);
    localparam logic [POS_W-1:0] POS_COUPLED  = POS_W'(20);
    localparam logic [POS_W-1:0] POS_MAGIC_END = POS_W'(8);

    // Byte codes
    localparam logic [7:0]  VER_MAJOR_MASK = 8'd240;
    localparam logic [7:0]  MAP_SILENT     = 8'd255;
    localparam logic [7:0]  FAMILY_RTP     = 8'd0;
    localparam logic [63:0] MAGIC          = 64'h4F70_7573_4865_6164; // "OpusHead"

    // One input transaction
    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
    } in_item_t;

    // One result transaction
    typedef struct packed {
        logic               kind;
        logic               valid_res;
        logic [7:0]         version;
        logic [7:0]         channels;
        logic [15:0]        preskip;
        logic [31:0]        sample_rate;
        logic signed [15:0] gain;
        logic [7:0]         map_family;
        logic [7:0]         stream_count;
        logic [7:0]         coupled_count;
        logic [7:0]         map_value;
        logic               last_result;
    } out_item_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_RECV,
        ST_SUMMARY,
        ST_MAP_READ,
        ST_MAP_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic byte_en;
        logic cnt_clr;
        logic cnt_inc;
        logic rd_en;
        logic emit_map;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hdr_ok;
        logic map_last;
    } status_t;

    // Magic byte at a position 0..7
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [5:0] sh;
        sh = 6'(7 - idx) << 3;
        return 8'(MAGIC >> sh);
    endfunction

endpackage

// File: rtl/oidh_ram.sv
// ----------------------------------------------------------------------------
// oidh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module oidh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/oidh_ctrl.sv
// ----------------------------------------------------------------------------
// oidh_ctrl
// Controller: receives header bytes, then sequences the summary transaction
// and, on a valid header, one map transaction per channel.
// ----------------------------------------------------------------------------
module oidh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic             last_byte,
    output logic             result_valid,
    input  logic             result_ready,
    output oidh_pkg::cmd_t    cmd,
    input  oidh_pkg::status_t status
);
    import oidh_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        item_ready   = 1'b0;
        result_valid = 1'b0;
        case (state_reg)
            ST_RECV:
            begin
                item_ready  = 1'b1;
                cmd.byte_en = item_valid;
                if (item_valid && last_byte)
                begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_SUMMARY:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    if (status.hdr_ok)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_MAP_READ;
                    end
                    else
                    begin
                        state_next = ST_RECV;
                    end
                end
            end
            ST_MAP_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_MAP_OUT;
            end
            ST_MAP_OUT:
            begin
                result_valid = 1'b1;
                cmd.emit_map = 1'b1;
                if (result_ready)
                begin
                    if (status.map_last)
                    begin
                        state_next = ST_RECV;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_MAP_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

endmodule

// File: rtl/oidh_datapath.sv
// ----------------------------------------------------------------------------
// oidh_datapath
// Datapath: byte position, field capture, per-byte checks, map store and
// result formatting.
// ----------------------------------------------------------------------------
module oidh_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  oidh_pkg::in_item_t  item,
    input  oidh_pkg::cmd_t      cmd,
    output oidh_pkg::status_t   status,
    output oidh_pkg::out_item_t result
);
    import oidh_pkg::*;

    logic [POS_W-1:0] pos_reg,     pos_next;
    logic             err_reg,     err_next;
    logic [7:0]       version_reg, version_next;
    logic [7:0]       channel_reg, channel_next;
    logic [15:0]      preskip_reg, preskip_next;
    logic [31:0]      rate_reg,    rate_next;
    logic [15:0]      gain_reg,    gain_next;
    logic [7:0]       family_reg,  family_next;
    logic [7:0]       stream_reg,  stream_next;
    logic [7:0]       coupled_reg, coupled_next;
    logic [IDX_W-1:0] cnt_reg,     cnt_next;

    logic [7:0]       b;
    logic [HE_W-1:0]  hdr_end;
    logic [HE_W-1:0]  hdr_end_fin;
    logic [POS_W:0]   pkt_len;
    logic [POS_W-1:0] map_off;
    logic [8:0]       sum_sc;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       rd_data;

    assign b = item.header_byte;

    // Header end for the family seen so far
    assign hdr_end = (family_reg == FAMILY_RTP) ? HE_W'(MIN_LEN)
                                                : HE_W'(MAP_BASE) + HE_W'(channel_reg);
    assign map_off = pos_reg - POS_W'(MAP_BASE);
    assign wr_addr = map_off[IDX_W-1:0];

    // Capture fields and run the per-byte checks
    always_comb
    begin
        pos_next     = pos_reg;
        err_next     = err_reg;
        version_next = version_reg;
        channel_next = channel_reg;
        preskip_next = preskip_reg;
        rate_next    = rate_reg;
        gain_next    = gain_reg;
        family_next  = family_reg;
        stream_next  = stream_reg;
        coupled_next = coupled_reg;
        wr_en        = 1'b0;
        sum_sc       = 9'(stream_reg) + 9'(coupled_reg);
        hdr_end_fin  = hdr_end;
        pkt_len      = 17'(pos_reg) + 17'd1;

        if (cmd.byte_en)
        begin
            // Start of a packet: drop everything from the last one
            if (pos_reg == '0)
            begin
                err_next     = 1'b0;
                version_next = '0;
                channel_next = '0;
                preskip_next = '0;
                rate_next    = '0;
                gain_next    = '0;
                family_next  = '0;
                stream_next  = '0;
                coupled_next = '0;
            end

            if (pos_reg < POS_MAGIC_END)
            begin
                if (b != magic_byte(pos_reg[2:0]))
                begin
                    err_next = 1'b1;
                end
            end
            else if (pos_reg == POS_VERSION)
            begin
                version_next = b;
                if ((b & VER_MAJOR_MASK) != '0)
                begin
                    err_next = 1'b1;
                end
            end
            else if (pos_reg == POS_CHANNELS)
            begin
                channel_next = b;
                if (b == '0 || 32'(b) > MAX_CHANNELS)
                begin
                    err_next = 1'b1;
                end
            end
            else if (pos_reg == POS_PRE_LO)
            begin
                preskip_next[7:0] = b;
            end
            else if (pos_reg == POS_PRE_HI)
            begin
                preskip_next[15:8] = b;
            end
            else if (pos_reg <= POS_RATE_3)
            begin
                rate_next[8*(pos_reg[1:0]) +: 8] = b;
            end
            else if (pos_reg == POS_GAIN_LO)
            begin
                gain_next[7:0] = b;
            end
            else if (pos_reg == POS_GAIN_HI)
            begin
                gain_next[15:8] = b;
            end
            else if (pos_reg == POS_FAMILY)
            begin
                family_next = b;
                if (b == FAMILY_RTP)
                begin
                    // Implied map 0,1 is supplied at emission time
                    if (channel_reg > 8'd2)
                    begin
                        err_next = 1'b1;
                    end
                    stream_next  = 8'd1;
                    coupled_next = (channel_reg > 8'd1) ? 8'd1 : 8'd0;
                end
            end
            else if (pos_reg >= POS_W'(hdr_end))
            begin
                // Trailing bytes are an error for versions 0 and 1
                if (version_reg <= 8'd1)
                begin
                    err_next = 1'b1;
                end
            end
            else if (pos_reg == POS_STREAMS)
            begin
                stream_next = b;
                if (b == '0)
                begin
                    err_next = 1'b1;
                end
            end
            else if (pos_reg == POS_COUPLED)
            begin
                coupled_next = b;
                if (b > stream_reg || (9'(b) + 9'(stream_reg)) > 9'd255)
                begin
                    err_next = 1'b1;
                end
            end
            else
            begin
                wr_en = (32'(map_off) < MAX_CHANNELS);
                if (9'(b) > sum_sc && b != MAP_SILENT)
                begin
                    err_next = 1'b1;
                end
            end

            // Advance position, saturating
            if (pos_reg != '1)
            begin
                pos_next = pos_reg + POS_W'(1);
            end

            // End of packet: length checks, then rewind
            if (item.last_byte)
            begin
                hdr_end_fin = (family_next == FAMILY_RTP)
                              ? HE_W'(MIN_LEN)
                              : HE_W'(MAP_BASE) + HE_W'(channel_next);
                if (pkt_len < 17'(MIN_LEN))
                begin
                    err_next = 1'b1;
                end
                else if (pkt_len < 17'(hdr_end_fin))
                begin
                    err_next = 1'b1;
                end
                pos_next = '0;
            end
        end
    end

    // Map entry counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            err_reg     <= 1'b0;
            version_reg <= '0;
            channel_reg <= '0;
            preskip_reg <= '0;
            rate_reg    <= '0;
            gain_reg    <= '0;
            family_reg  <= '0;
            stream_reg  <= '0;
            coupled_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            err_reg     <= err_next;
            version_reg <= version_next;
            channel_reg <= channel_next;
            preskip_reg <= preskip_next;
            rate_reg    <= rate_next;
            gain_reg    <= gain_next;
            family_reg  <= family_next;
            stream_reg  <= stream_next;
            coupled_reg <= coupled_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Stream map store
    oidh_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHANNELS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (b),
        .rd_en   (cmd.rd_en),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    // Status to the controller
    assign status.hdr_ok   = !err_reg && (32'(channel_reg) <= MAX_CHANNELS);
    assign status.map_last = ((8'(cnt_reg) + 8'd1) == channel_reg);

    // Format the outgoing transaction
    always_comb
    begin
        result = '0;
        if (cmd.emit_map)
        begin
            result.kind        = 1'b1;
            result.valid_res   = 1'b1;
            result.map_value   = (family_reg == FAMILY_RTP) ? 8'(cnt_reg) : rd_data;
            result.last_result = status.map_last;
        end
        else if (status.hdr_ok)
        begin
            result.valid_res      = 1'b1;
            result.version        = version_reg;
            result.channels       = channel_reg;
            result.preskip        = preskip_reg;
            result.sample_rate    = rate_reg;
            result.gain           = gain_reg;
            result.map_family     = family_reg;
            result.stream_count   = stream_reg;
            result.coupled_count  = coupled_reg;
            result.last_result    = (channel_reg == '0);
        end
        else
        begin
            result.last_result = 1'b1;
        end
    end

endmodule

// File: rtl/opus_id_header_parser.sv
// Order: the summary transaction is offered the cycle after the last byte; once
// a map transaction is taken, ST_MAP_READ reads the next, ST_MAP_OUT offers it.
// Throughput: one header byte per cycle while receiving; after the last byte
// the block takes no byte until the summary and, on a valid header, one map
// transaction per channel (map RAM read, then show) have been taken.
// Reset: rst_n clears position, flags, fields and controller; map store is not.
// ----------------------------------------------------------------------------
// opus_id_header_parser
// Top level: Ogg Opus identification header parser with a controller and a
// datapath joined by command and status structs.
// ----------------------------------------------------------------------------
module opus_id_header_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  oidh_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output oidh_pkg::out_item_t result
);
    import oidh_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencing
    oidh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .last_byte    (item.last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    // Field capture, checks and result formatting
    oidh_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule
